[rtl/core/rti_pkg.sv]
// shared types and constants for the ray/triangle intersection pipeline
package rti_pkg;

    localparam int DOT_W = 100;
    localparam int R_W   = DOT_W + 1;
    localparam int DIV_N = 32;
    localparam int LAT   = 45;

    localparam logic        KIND_LOAD = 1'b0;
    localparam logic        KIND_RAY  = 1'b1;
    localparam logic [30:0] THR_RESET = 31'd7;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               kind;
        logic [1:0]         vertex_index;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_rti_in;

    typedef struct packed {
        logic               hit_flag;
        logic signed [31:0] hit_distance;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_rti_out;

endpackage

[rtl/core/ray_triangle_intersect_top.sv]
// pipelined moller-trumbore ray/triangle test in signed q16.16
//
// usage:
//   input beats are taken on start while busy is low; busy never rises, so a
//   beat can enter every cycle. a load beat (kind 0) writes one vertex of the
//   triangle store and gives no result; a ray beat (kind 1) gives one result.
//   cast rays only after all three vertices are loaded.
//   a ray result appears on o_result with o_result_valid high for one cycle,
//   in order of entry. one ray per cycle sustained. the pipeline is 8 stages
//   of cross/dot arithmetic (dot-product multipliers split into 33x33 and 35x33
//   partial products), a divider entry stage and a 32-stage bit-per-stage
//   restoring divider for t, and 4 stages for the hit point.
//   the threshold register is written over i_cfg_valid / o_cfg_ready (ready is
//   always high); the user must write it only while no ray is in flight: the
//   block itself does not enforce it. reset clears the pipeline valid bits and
//   sets the threshold to 7; the vertex store is not cleared. the receiver
//   cannot stall: every result is taken in the cycle it is shown.
module ray_triangle_intersect_top
    import rti_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_rti_in     i_item,
    output logic        o_result_valid,
    output t_rti_out    o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);

    typedef struct packed {
        logic               hit;
        logic               neg;
        logic               ovf;
        logic [DOT_W-1:0]   det;
        logic [R_W-1:0]     rem;
        logic [31:0]        nlo;
        logic [31:0]        quo;
        logic [5:0][31:0]   od;
    } t_dv;

    logic               acc;
    logic               ray_acc;
    logic [30:0]        r_thr;
    logic signed [31:0] r_vtx [9];
    logic signed [31:0] in_org [3];
    logic signed [31:0] in_dir [3];

    logic [7:0]         r_sv;
    logic [5:0][31:0]   r_od [8];

    logic signed [32:0] r1_e1 [3];
    logic signed [32:0] r1_e2 [3];
    logic signed [32:0] r1_s  [3];
    logic signed [31:0] s1_d  [3];

    logic signed [65:0] r2_pm [6];
    logic signed [65:0] r2_qm [6];
    logic signed [32:0] r2_e1 [3];
    logic signed [32:0] r2_e2 [3];
    logic signed [32:0] r2_s  [3];

    logic signed [66:0] r3_p  [3];
    logic signed [66:0] r3_q  [3];
    logic signed [32:0] r3_e1 [3];
    logic signed [32:0] r3_e2 [3];
    logic signed [32:0] r3_s  [3];

    logic signed [66:0] s3_x [4][3];
    logic signed [32:0] s3_y [4][3];

    logic signed [65:0]      r4_lo   [4][3];
    logic signed [67:0]      r4_hi   [4][3];
    logic signed [DOT_W-1:0] r5_term [4][3];
    logic signed [DOT_W-1:0] r6_dot  [4];
    logic signed [DOT_W-1:0] r7_dot  [4];

    logic [DOT_W-1:0]        n_eps;
    logic signed [DOT_W:0]   n_uv;
    logic                    n_hit;
    logic                    r8_hit;
    logic                    r8_neg;
    logic [DOT_W-1:0]        r8_det;
    logic [DOT_W-1:0]        r8_mag;

    t_dv                r_dv [DIV_N+1];
    logic [DIV_N:0]     r_dv_v;
    logic [R_W-1:0]     n_trial [DIV_N];
    logic               n_ge    [DIV_N];

    logic signed [31:0] n_t;
    logic               r_t_v;
    logic               r_t_hit;
    logic signed [31:0] r_t;
    logic [5:0][31:0]   r_t_od;

    logic               r_m_v;
    logic               r_m_hit;
    logic signed [31:0] r_m_t;
    logic signed [63:0] r_m_prod [3];
    logic [2:0][31:0]   r_m_org;

    logic               r_val_v;
    logic               r_val_hit;
    logic signed [31:0] r_val_t;
    logic signed [47:0] r_val [3];
    logic [2:0][31:0]   r_val_org;
    logic signed [63:0] n_bias [3];

    logic signed [48:0] n_sum [3];
    logic signed [31:0] n_pt  [3];
    logic               r_o_v;
    t_rti_out           r_o;

    assign busy           = 1'b0;
    assign o_cfg_ready    = 1'b1;
    assign acc            = start && !busy;
    assign ray_acc        = acc && (i_item.kind == KIND_RAY);
    assign o_result_valid = r_o_v;
    assign o_result       = r_o;

    assign in_org[0] = i_item.origin_x;
    assign in_org[1] = i_item.origin_y;
    assign in_org[2] = i_item.origin_z;
    assign in_dir[0] = i_item.dir_x;
    assign in_dir[1] = i_item.dir_y;
    assign in_dir[2] = i_item.dir_z;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // vertex store
    always_ff @(posedge i_clk) begin
        if (acc && (i_item.kind == KIND_LOAD)) begin
            for (int v = 0; v < 3; v++) begin
                if (i_item.vertex_index == 2'(v)) begin
                    r_vtx[v*3]   <= i_item.vertex_x;
                    r_vtx[v*3+1] <= i_item.vertex_y;
                    r_vtx[v*3+2] <= i_item.vertex_z;
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv    <= '0;
            r_dv_v  <= '0;
            r_t_v   <= 1'b0;
            r_m_v   <= 1'b0;
            r_val_v <= 1'b0;
            r_o_v   <= 1'b0;
        end else begin
            r_sv    <= {r_sv[6:0], ray_acc};
            r_dv_v  <= {r_dv_v[DIV_N-1:0], r_sv[7]};
            r_t_v   <= r_dv_v[DIV_N];
            r_m_v   <= r_t_v;
            r_val_v <= r_m_v;
            r_o_v   <= r_val_v;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s1_d[k] = $signed(r_od[0][3+k]);
        end
    end

    // dot product operands: det = p.e1, u = p.s, v = q.d, t = q.e2
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s3_x[0][k] = r3_p[k];
            s3_y[0][k] = r3_e1[k];
            s3_x[1][k] = r3_p[k];
            s3_y[1][k] = r3_s[k];
            s3_x[2][k] = r3_q[k];
            s3_y[2][k] = $signed({r_od[2][3+k][31], r_od[2][3+k]});
            s3_x[3][k] = r3_q[k];
            s3_y[3][k] = r3_e2[k];
        end
    end

    // hit tests on numerators
    always_comb begin
        n_eps = DOT_W'({r_thr, 32'h0});
        n_uv  = (DOT_W+1)'(r7_dot[1]) + (DOT_W+1)'(r7_dot[2]);
        n_hit = (r7_dot[0] != '0)
             && ($unsigned(r7_dot[0]) >= n_eps)
             && !r7_dot[1][DOT_W-1] && (r7_dot[1] <= r7_dot[0])
             && !r7_dot[2][DOT_W-1] && (r7_dot[2] <= r7_dot[0])
             && (n_uv <= (DOT_W+1)'(r7_dot[0]));
    end

    // one quotient bit per stage
    always_comb begin
        for (int j = 0; j < DIV_N; j++) begin
            n_trial[j] = {r_dv[j].rem[R_W-2:0], r_dv[j].nlo[31]};
            n_ge[j]    = n_trial[j] >= {1'b0, r_dv[j].det};
        end
    end

    // t with saturation
    always_comb begin
        n_t = '0;
        if (r_dv[DIV_N].hit) begin
            if (r_dv[DIV_N].neg) begin
                if (r_dv[DIV_N].ovf || (r_dv[DIV_N].quo > 32'h8000_0000)) begin
                    n_t = SAT_MIN;
                end else begin
                    n_t = -$signed(r_dv[DIV_N].quo);
                end
            end else begin
                if (r_dv[DIV_N].ovf || r_dv[DIV_N].quo[31]) begin
                    n_t = SAT_MAX;
                end else begin
                    n_t = $signed(r_dv[DIV_N].quo);
                end
            end
        end
    end

    // hit point: truncate toward zero, add origin, saturate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_bias[k] = r_m_prod[k] + $signed({48'h0, {16{r_m_prod[k][63]}}});
            n_sum[k]  = 49'($signed(r_val_org[k])) + 49'(r_val[k]);
            if (n_sum[k][48:31] == '0 || n_sum[k][48:31] == '1) begin
                n_pt[k] = n_sum[k][31:0];
            end else if (n_sum[k][48]) begin
                n_pt[k] = SAT_MIN;
            end else begin
                n_pt[k] = SAT_MAX;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // edges and ray offset
        for (int k = 0; k < 3; k++) begin
            r1_e1[k] <= {r_vtx[3+k][31], r_vtx[3+k]} - {r_vtx[k][31], r_vtx[k]};
            r1_e2[k] <= {r_vtx[6+k][31], r_vtx[6+k]} - {r_vtx[k][31], r_vtx[k]};
            r1_s[k]  <= {in_org[k][31], in_org[k]} - {r_vtx[k][31], r_vtx[k]};
        end
        r_od[0] <= {in_dir[2], in_dir[1], in_dir[0], in_org[2], in_org[1], in_org[0]};
        for (int i = 1; i < 8; i++) begin
            r_od[i] <= r_od[i-1];
        end

        // cross product terms: p = d x e2, q = s x e1
        r2_pm[0] <= s1_d[1] * r1_e2[2];
        r2_pm[1] <= s1_d[2] * r1_e2[1];
        r2_pm[2] <= s1_d[2] * r1_e2[0];
        r2_pm[3] <= s1_d[0] * r1_e2[2];
        r2_pm[4] <= s1_d[0] * r1_e2[1];
        r2_pm[5] <= s1_d[1] * r1_e2[0];
        r2_qm[0] <= r1_s[1] * r1_e1[2];
        r2_qm[1] <= r1_s[2] * r1_e1[1];
        r2_qm[2] <= r1_s[2] * r1_e1[0];
        r2_qm[3] <= r1_s[0] * r1_e1[2];
        r2_qm[4] <= r1_s[0] * r1_e1[1];
        r2_qm[5] <= r1_s[1] * r1_e1[0];
        for (int k = 0; k < 3; k++) begin
            r2_e1[k] <= r1_e1[k];
            r2_e2[k] <= r1_e2[k];
            r2_s[k]  <= r1_s[k];
            r3_p[k]  <= 67'(r2_pm[2*k]) - 67'(r2_pm[2*k+1]);
            r3_q[k]  <= 67'(r2_qm[2*k]) - 67'(r2_qm[2*k+1]);
            r3_e1[k] <= r2_e1[k];
            r3_e2[k] <= r2_e2[k];
            r3_s[k]  <= r2_s[k];
        end

        // dot products over split operands
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 3; k++) begin
                r4_lo[j][k]   <= $signed({1'b0, s3_x[j][k][31:0]}) * s3_y[j][k];
                r4_hi[j][k]   <= $signed(s3_x[j][k][66:32]) * s3_y[j][k];
                r5_term[j][k] <= (DOT_W'(r4_hi[j][k]) <<< 32) + DOT_W'(r4_lo[j][k]);
            end
            r6_dot[j] <= r5_term[j][0] + r5_term[j][1] + r5_term[j][2];
            r7_dot[j] <= r6_dot[0][DOT_W-1] ? -r6_dot[j] : r6_dot[j];
        end

        r8_hit <= n_hit;
        r8_neg <= r7_dot[3][DOT_W-1];
        r8_det <= r7_dot[0];
        r8_mag <= r7_dot[3][DOT_W-1] ? -r7_dot[3] : r7_dot[3];

        // divider entry
        r_dv[0].hit <= r8_hit;
        r_dv[0].neg <= r8_neg;
        r_dv[0].ovf <= (r8_mag >> 16) >= r8_det;
        r_dv[0].det <= r8_det;
        r_dv[0].rem <= R_W'(r8_mag >> 16);
        r_dv[0].nlo <= {r8_mag[15:0], 16'h0};
        r_dv[0].quo <= '0;
        r_dv[0].od  <= r_od[7];
        for (int j = 0; j < DIV_N; j++) begin
            r_dv[j+1].hit <= r_dv[j].hit;
            r_dv[j+1].neg <= r_dv[j].neg;
            r_dv[j+1].ovf <= r_dv[j].ovf;
            r_dv[j+1].det <= r_dv[j].det;
            r_dv[j+1].rem <= n_ge[j] ? n_trial[j] - {1'b0, r_dv[j].det} : n_trial[j];
            r_dv[j+1].nlo <= {r_dv[j].nlo[30:0], 1'b0};
            r_dv[j+1].quo <= {r_dv[j].quo[30:0], n_ge[j]};
            r_dv[j+1].od  <= r_dv[j].od;
        end

        r_t     <= n_t;
        r_t_hit <= r_dv[DIV_N].hit;
        r_t_od  <= r_dv[DIV_N].od;

        r_m_hit <= r_t_hit;
        r_m_t   <= r_t;
        r_m_org <= r_t_od[2:0];
        for (int k = 0; k < 3; k++) begin
            r_m_prod[k] <= r_t * $signed(r_t_od[3+k]);
            r_val[k]    <= n_bias[k][63:16];
        end
        r_val_hit <= r_m_hit;
        r_val_t   <= r_m_t;
        r_val_org <= r_m_org;

        r_o.hit_flag     <= r_val_hit;
        r_o.hit_distance <= r_val_t;
        r_o.point_x      <= r_val_hit ? n_pt[0] : '0;
        r_o.point_y      <= r_val_hit ? n_pt[1] : '0;
        r_o.point_z      <= r_val_hit ? n_pt[2] : '0;
    end

    // every result traces back to a ray beat
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy && (i_item.kind == KIND_RAY), LAT))
        else $error("result without matching ray beat");

    // a miss carries no distance and no point
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.hit_flag) |->
            (o_result.hit_distance == '0 && o_result.point_x == '0 &&
             o_result.point_y == '0 && o_result.point_z == '0))
        else $error("miss with nonzero payload");

    // divider remainder stays below the divisor
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_v[DIV_N] && r_dv[DIV_N].hit && !r_dv[DIV_N].ovf) |->
            (r_dv[DIV_N].rem < {1'b0, r_dv[DIV_N].det}))
        else $error("divider remainder out of range");

    // quotient overflow saturates t
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_v[DIV_N] && r_dv[DIV_N].hit && r_dv[DIV_N].ovf) |=>
            (r_t == SAT_MAX || r_t == SAT_MIN))
        else $error("t overflow not saturated");

endmodule
